### rtl/btk_pkg.sv
// Shared types and constants for the bounded top-k sorted insertion table.
`timescale 1ns / 1ps

package btk_pkg;

    // Number of slots in the table
    localparam int TABLE_DEPTH = 8;
    // Width of the entry count, which reaches TABLE_DEPTH itself
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    // Slots reachable by the 3-bit read index
    localparam int READ_SLOTS = (TABLE_DEPTH < 8) ? TABLE_DEPTH : 8;

    localparam int KEY_W = 32;
    localparam int TAG_W = 24;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    // One table slot
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    // Command broadcast to every cell in a cycle
    typedef struct packed {
        logic                    ins;
        logic                    clr;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_cmd;

endpackage

### rtl/btk_cell.sv
// One slot of the sorted table: compares the broadcast key and shifts from its neighbor.
`timescale 1ns / 1ps

module btk_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  btk_pkg::t_cmd   i_cmd,
    input  btk_pkg::t_entry i_prev,
    input  logic           i_prev_place,
    output btk_pkg::t_entry o_entry,
    output logic           o_place
);

    btk_pkg::t_entry r_entry;
    btk_pkg::t_entry n_entry;

    // Slot is at or past the insertion point when it cannot keep its place
    assign o_place = !(r_entry.valid && (r_entry.key >= i_cmd.key));
    assign o_entry = r_entry;

    // Take the neighbor's entry past the insertion point, the new entry at it
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.clr) begin
            n_entry.valid = 1'b0;
        end else if (i_cmd.ins) begin
            if (i_prev_place) begin
                n_entry = i_prev;
            end else if (o_place) begin
                n_entry.valid = 1'b1;
                n_entry.key   = i_cmd.key;
                n_entry.tag   = i_cmd.tag;
            end
        end
    end

    // Hold the slot; only the valid bit needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.key <= n_entry.key;
        r_entry.tag <= n_entry.tag;
    end

endmodule

### rtl/bounded_top_k_sorted_insert_top.sv
// Top level of the bounded top-k sorted insertion table: cell chain and result register.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s (req)   in   s_tvalid/s_tready  s_tuser opcode, s_tdata key, tags, read index
// m (res)   out  m_tvalid/m_tready  m_tdata accepted, slot, total, in use, key, tag
//
// For every request, all cells compare against the broadcast key and shift toward
// the bottom in the same cycle, so a request can follow every cycle unless a result
// stalls. The result is written into the output register when the request is accepted.
// Synchronous active-low reset empties the table at once (valid bits cleared).
// A stalled result holds; a new request is taken whenever the output register is
// empty or is being drained in the same cycle.

module bounded_top_k_sorted_insert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: key_value[31:0], tag_byte0[39:32], tag_byte1[47:40],
    // tag_byte2[55:48], read_index[58:56], zero[63:59]
    input  logic [63:0] s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: accepted[0], insert_slot[3:1], entry_total[7:4],
    // slot_in_use[8], read_key[40:9], read_tag[64:41], zero[71:65]
    output logic [71:0] m_tdata
);

    localparam int N = btk_pkg::TABLE_DEPTH;

    // Unpack the request
    btk_pkg::t_opcode                 w_op;
    logic signed [btk_pkg::KEY_W-1:0] w_key;
    logic [btk_pkg::TAG_W-1:0]        w_tag;
    logic [2:0]                       w_idx;
    logic                             w_fire;

    assign w_op   = btk_pkg::t_opcode'(s_tuser);
    assign w_key  = s_tdata[31:0];
    assign w_tag  = s_tdata[55:32];
    assign w_idx  = s_tdata[58:56];
    assign w_fire = s_tvalid && s_tready;

    // Broadcast command
    btk_pkg::t_cmd w_cmd;
    logic          w_key_pos;

    assign w_key_pos = !w_key[btk_pkg::KEY_W-1] && (|w_key);

    always_comb begin
        w_cmd.ins = w_fire && (w_op == btk_pkg::OP_INSERT) && w_key_pos;
        w_cmd.clr = w_fire && (w_op == btk_pkg::OP_CLEAR);
        w_cmd.key = w_key;
        w_cmd.tag = w_tag;
    end

    // Cell chain
    btk_pkg::t_entry w_entry [N];
    btk_pkg::t_entry w_prev  [N];
    logic [N-1:0]    w_place;
    logic [N-1:0]    w_prev_place;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g]       = '0;
            assign w_prev_place[g] = 1'b0;
        end else begin : g_link
            assign w_prev[g]       = w_entry[g-1];
            assign w_prev_place[g] = w_place[g-1];
        end

        btk_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev       (w_prev[g]),
            .i_prev_place (w_prev_place[g]),
            .o_entry      (w_entry[g]),
            .o_place      (w_place[g])
        );
    end

    // Insertion slot: encode the first cell that takes the new entry
    logic       w_accepted;
    logic [2:0] w_slot;

    assign w_accepted = w_cmd.ins && w_place[N-1];

    always_comb begin
        w_slot = '0;
        for (int i = 0; i < N; i++) begin
            if (w_place[i] && !w_prev_place[i]) begin
                w_slot = w_slot | 3'(i);
            end
        end
    end

    // Read selection over the slots the index reaches
    btk_pkg::t_entry w_rd;

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < btk_pkg::READ_SLOTS; i++) begin
            if (w_idx == 3'(i)) begin
                w_rd = w_entry[i];
            end
        end
    end

    // Entry count
    logic [btk_pkg::CNT_W-1:0] r_count;
    logic [btk_pkg::CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (w_cmd.clr) begin
            n_count = '0;
        end else if (w_accepted && (r_count < btk_pkg::CNT_W'(N))) begin
            n_count = r_count + 1'b1;
        end
    end

    // Result fields
    logic                      w_rd_en;
    logic                      w_in_use;
    logic [71:0]               w_res;

    assign w_rd_en  = w_op == btk_pkg::OP_READ;
    assign w_in_use = w_rd_en && w_rd.valid;

    always_comb begin
        w_res         = '0;
        w_res[0]      = w_accepted;
        w_res[3:1]    = w_accepted ? w_slot : 3'd0;
        w_res[7:4]    = 4'(n_count);
        w_res[8]      = w_in_use;
        w_res[40:9]   = w_in_use ? w_rd.key : '0;
        w_res[64:41]  = w_in_use ? w_rd.tag : '0;
    end

    // Output register and count
    logic        r_m_valid;
    logic [71:0] r_m_data;

    assign s_tready = !r_m_valid || m_tready;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_m_data <= w_res;
        end
    end

    // Count never exceeds the table size
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= btk_pkg::CNT_W'(N))
        else $error("entry count above table depth");

    // A cleared table reports no entries afterwards
    a_clear_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr |=> (r_count == '0) && !w_entry[0].valid)
        else $error("clear left entries behind");

    // Accepted insert leaves the top slot valid and a nonzero count
    a_accept_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accepted |=> w_entry[0].valid && (r_count != '0))
        else $error("accepted insert left table empty");

    // Valid bits as a prefix: the last slot is valid only if the top slot is
    a_valid_prefix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (N < 2) || !w_entry[N-1].valid || w_entry[0].valid)
        else $error("valid bits out of order");

endmodule
